[hw/rtl/kdtl_pkg.sv]
// Shared types and constants of the knob damping torque loop.
package kdtl_pkg;

    // Build-time defaults for the top-level parameters
    localparam int POLE_PAIRS_DEF = 7;
    localparam int ANGLE_BITS_DEF = 12;
    localparam int ANGLE_BITS_MAX = 16;

    // Port field widths
    localparam int ANGLE_W  = 12;
    localparam int TORQUE_W = 16;
    localparam int ELEC_W   = 12;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // Register file
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 15;

    localparam logic [GAIN_W-1:0] DGAIN_RST = 16'd256;
    localparam logic [GAIN_W-1:0] SGAIN_RST = 16'd256;
    localparam logic [LIM_W-1:0]  LIM_RST   = 15'd10240;

    // Filter coefficients, Q0.16
    localparam logic signed [16:0] SPEED_K  = 17'sd13107;
    localparam logic signed [16:0] DAMP_K   = 17'sd3277;
    localparam logic signed [16:0] SMOOTH_K = 17'sd5243;

    // Shared multiplier and filter state widths
    localparam int FILT_W = 24;
    localparam int OPA_W  = 25;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SH_W   = PROD_W - 16;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_DGAIN  = 3'd1,
        REG_SGAIN  = 3'd2,
        REG_LIMIT  = 3'd3,
        REG_OFFSET = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic              mode;
        logic [GAIN_W-1:0] damping_gain;
        logic [GAIN_W-1:0] smooth_gain;
        logic [LIM_W-1:0]  trq_bound;
        logic [ELEC_W-1:0] zero_offset;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPD_MUL,
        S_SPD_ACC,
        S_ELEC,
        S_CLAMP,
        S_SM_OP,
        S_SM_MUL,
        S_SM_ACC,
        S_OUT
    } seq_state_t;

endpackage

[hw/rtl/kdtl_regs.sv]
// APB configuration registers of the knob damping torque loop.
module kdtl_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kdtl_pkg::APB_AW-1:0] paddr,
    input  logic [kdtl_pkg::APB_DW-1:0] pwdata,
    output logic [kdtl_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output kdtl_pkg::cfg_t              cfg,
    output logic                        mode_clr
);

    kdtl_pkg::cfg_t cfg_reg, cfg_next;
    logic           wr_en;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[4:2];

    // write decode
    always_comb begin
        cfg_next = cfg_reg;
        mode_clr = 1'b0;
        if (wr_en) begin
            unique case (idx)
                kdtl_pkg::REG_MODE: begin
                    cfg_next.mode = pwdata[0];
                    mode_clr      = 1'b1;
                end
                kdtl_pkg::REG_DGAIN:  cfg_next.damping_gain = pwdata[kdtl_pkg::GAIN_W-1:0];
                kdtl_pkg::REG_SGAIN:  cfg_next.smooth_gain  = pwdata[kdtl_pkg::GAIN_W-1:0];
                kdtl_pkg::REG_LIMIT:  cfg_next.trq_bound    = pwdata[kdtl_pkg::LIM_W-1:0];
                kdtl_pkg::REG_OFFSET: cfg_next.zero_offset  = pwdata[kdtl_pkg::ELEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode         <= 1'b0;
            cfg_reg.damping_gain <= kdtl_pkg::DGAIN_RST;
            cfg_reg.smooth_gain  <= kdtl_pkg::SGAIN_RST;
            cfg_reg.trq_bound    <= kdtl_pkg::LIM_RST;
            cfg_reg.zero_offset  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (idx)
            kdtl_pkg::REG_MODE:   prdata = kdtl_pkg::APB_DW'(cfg_reg.mode);
            kdtl_pkg::REG_DGAIN:  prdata = kdtl_pkg::APB_DW'(cfg_reg.damping_gain);
            kdtl_pkg::REG_SGAIN:  prdata = kdtl_pkg::APB_DW'(cfg_reg.smooth_gain);
            kdtl_pkg::REG_LIMIT:  prdata = kdtl_pkg::APB_DW'(cfg_reg.trq_bound);
            kdtl_pkg::REG_OFFSET: prdata = kdtl_pkg::APB_DW'(cfg_reg.zero_offset);
            default:              prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/kdtl_mul.sv]
// Shared signed multiplier with registered product.
module kdtl_mul (
    input  logic                               aclk,
    input  logic signed [kdtl_pkg::OPA_W-1:0]  op_a,
    input  logic signed [kdtl_pkg::OPB_W-1:0]  op_b,
    output logic signed [kdtl_pkg::PROD_W-1:0] prod
);

    logic signed [kdtl_pkg::PROD_W-1:0] prod_reg;

    // product taken every cycle, the sequencer picks the one it needs
    always_ff @(posedge aclk) begin
        prod_reg <= kdtl_pkg::PROD_W'(op_a) * kdtl_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/kdtl_seq.sv]
// Sequencer and filter state: drives the shared multiplier step by step.
module kdtl_seq #(
    parameter int POLE_PAIRS = kdtl_pkg::POLE_PAIRS_DEF,
    parameter int ANGLE_BITS = kdtl_pkg::ANGLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kdtl_pkg::cfg_t                     cfg,
    input  logic                               mode_clr,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kdtl_pkg::ANGLE_W-1:0]       angle_in,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kdtl_pkg::TORQUE_W-1:0]      torque_cmd,
    output logic [kdtl_pkg::ELEC_W-1:0]        elec_angle,
    output logic signed [kdtl_pkg::OPA_W-1:0]  op_a,
    output logic signed [kdtl_pkg::OPB_W-1:0]  op_b,
    input  logic signed [kdtl_pkg::PROD_W-1:0] prod
);

    localparam int AB  = ANGLE_BITS;
    localparam int FW  = kdtl_pkg::FILT_W;
    localparam int AW  = kdtl_pkg::OPA_W;
    localparam int BW  = kdtl_pkg::OPB_W;
    localparam int TW  = kdtl_pkg::TORQUE_W;
    localparam int MAXW = kdtl_pkg::ANGLE_BITS_MAX;

    kdtl_pkg::seq_state_t state_reg, state_next;

    logic                 primed_reg, primed_next;
    logic [AB-1:0]        prev_reg, prev_next;
    logic signed [FW-1:0] f_reg, f_next;
    logic signed [FW-1:0] s_reg, s_next;
    logic signed [AW-1:0] op_a_reg, op_a_next;
    logic signed [BW-1:0] op_b_reg, op_b_next;
    logic signed [TW-1:0] raw_reg, raw_next;
    logic [AB-1:0]        elec_reg, elec_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TW-1:0]        m_torque_reg, m_torque_next;
    logic [kdtl_pkg::ELEC_W-1:0] m_elec_reg, m_elec_next;

    logic                 accept;
    logic                 out_free;
    logic [MAXW-1:0]      angle_wide;
    logic [AB-1:0]        angle_ab;
    logic [MAXW-1:0]      offset_wide;
    logic [AB-1:0]        diff;
    logic signed [AB-1:0] speed;
    logic signed [kdtl_pkg::SH_W-1:0] sh;
    logic signed [kdtl_pkg::SH_W:0]   raw_ext, raw_sgn, lim_s, raw_clamp;
    logic [MAXW-1:0]      elec_wide;

    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_valid_reg | m_tready;

    // angle into the working width, wrapped difference to the last tick
    assign angle_wide  = MAXW'(angle_in);
    assign angle_ab    = angle_wide[AB-1:0];
    assign offset_wide = MAXW'(cfg.zero_offset);
    assign diff        = angle_ab - prev_reg;
    assign speed       = primed_reg ? $signed(diff) : '0;

    // product scaled down by 2^16, rounding toward minus infinity
    assign sh = $signed(prod[kdtl_pkg::PROD_W-1:16]);

    // raw torque with sign by mode, clamped to the limit
    always_comb begin
        raw_ext = {sh[kdtl_pkg::SH_W-1], sh};
        raw_sgn = cfg.mode ? raw_ext : -raw_ext;
        lim_s   = $signed((kdtl_pkg::SH_W + 1)'(cfg.trq_bound));
        if (raw_sgn > lim_s) begin
            raw_clamp = lim_s;
        end else if (raw_sgn < -lim_s) begin
            raw_clamp = -lim_s;
        end else begin
            raw_clamp = raw_sgn;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kdtl_pkg::S_IDLE:    if (s_tvalid) state_next = kdtl_pkg::S_SPD_MUL;
            kdtl_pkg::S_SPD_MUL: state_next = kdtl_pkg::S_SPD_ACC;
            kdtl_pkg::S_SPD_ACC: state_next = kdtl_pkg::S_ELEC;
            kdtl_pkg::S_ELEC:    state_next = kdtl_pkg::S_CLAMP;
            kdtl_pkg::S_CLAMP:   state_next = kdtl_pkg::S_SM_OP;
            kdtl_pkg::S_SM_OP:   state_next = kdtl_pkg::S_SM_MUL;
            kdtl_pkg::S_SM_MUL:  state_next = kdtl_pkg::S_SM_ACC;
            kdtl_pkg::S_SM_ACC:  state_next = kdtl_pkg::S_OUT;
            kdtl_pkg::S_OUT:     if (out_free) state_next = kdtl_pkg::S_IDLE;
            default:             state_next = kdtl_pkg::S_IDLE;
        endcase
    end

    // datapath per step
    always_comb begin
        primed_next   = primed_reg;
        prev_next     = prev_reg;
        f_next        = f_reg;
        s_next        = s_reg;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        raw_next      = raw_reg;
        elec_next     = elec_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_torque_next = m_torque_reg;
        m_elec_next   = m_elec_reg;
        elec_wide     = MAXW'(elec_reg);
        unique case (state_reg)
            kdtl_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    primed_next = 1'b1;
                    prev_next   = angle_ab;
                    op_a_next   = (AW'(speed) <<< 8) - AW'(f_reg);
                    op_b_next   = kdtl_pkg::SPEED_K;
                end
            end
            kdtl_pkg::S_SPD_MUL: begin
                // electrical angle product goes in behind the speed product
                op_a_next = $signed(AW'(prev_reg));
                op_b_next = BW'(POLE_PAIRS);
            end
            kdtl_pkg::S_SPD_ACC: begin
                f_next    = f_reg + sh[FW-1:0];
                op_a_next = AW'(f_next);
                op_b_next = $signed({1'b0, cfg.mode ? cfg.smooth_gain : cfg.damping_gain});
            end
            kdtl_pkg::S_ELEC: begin
                elec_next = prod[AB-1:0] - offset_wide[AB-1:0];
            end
            kdtl_pkg::S_CLAMP: begin
                raw_next = raw_clamp[TW-1:0];
            end
            kdtl_pkg::S_SM_OP: begin
                op_a_next = $signed({raw_reg[TW-1], raw_reg, 8'b0}) - AW'(s_reg);
                op_b_next = cfg.mode ? kdtl_pkg::SMOOTH_K : kdtl_pkg::DAMP_K;
            end
            kdtl_pkg::S_SM_MUL: ;
            kdtl_pkg::S_SM_ACC: begin
                s_next = s_reg + sh[FW-1:0];
            end
            kdtl_pkg::S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_torque_next = s_reg[FW-1:FW-TW];
                    m_elec_next   = elec_wide[kdtl_pkg::ELEC_W-1:0];
                end
            end
            default: ;
        endcase
        // a mode write restarts both filters
        if (mode_clr) begin
            primed_next = 1'b0;
            f_next      = '0;
            s_next      = '0;
        end
    end

    // control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kdtl_pkg::S_IDLE;
            primed_reg  <= 1'b0;
            prev_reg    <= '0;
            f_reg       <= '0;
            s_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            primed_reg  <= primed_next;
            prev_reg    <= prev_next;
            f_reg       <= f_next;
            s_reg       <= s_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // operands and result words
    always_ff @(posedge aclk) begin
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        raw_reg      <= raw_next;
        elec_reg     <= elec_next;
        m_torque_reg <= m_torque_next;
        m_elec_reg   <= m_elec_next;
    end

    assign s_tready   = (state_reg == kdtl_pkg::S_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign torque_cmd = m_torque_reg;
    assign elec_angle = m_elec_reg;
    assign op_a       = op_a_reg;
    assign op_b       = op_b_reg;

    // an accepted word starts the speed multiply
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == kdtl_pkg::S_SPD_MUL)
        else $error("accepted word did not start the sequence");

    // any tick without a mode write in that cycle leaves the speed filter primed
    a_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !mode_clr |=> primed_reg)
        else $error("speed filter not primed after a tick");

    // clamped torque stays inside the limit
    a_raw_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kdtl_pkg::S_SM_OP |->
            ($signed((TW+1)'(raw_reg)) <= $signed((TW+1)'(cfg.trq_bound)) &&
             $signed((TW+1)'(raw_reg)) >= -$signed((TW+1)'(cfg.trq_bound))))
        else $error("raw torque outside limit");

    // leaving the output step always presents a word
    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kdtl_pkg::S_OUT && out_free |=> m_valid_reg)
        else $error("result word not presented");

endmodule

[hw/rtl/knob_damping_torque_loop.sv]
// Top level of the knob damping torque loop: registers, sequencer, shared multiplier.
//
//  port group   dir    word / fields
//  s_*          in     s_tdata[11:0] angle_counts
//  m_*          out    m_tdata[15:0] torque_cmd, [27:16] elec_angle
//  APB p*       cfg    0 mode, 1 damping gain, 2 smooth gain, 3 limit, 4 offset
//
// The result word is presented once the eight sequencer steps around the
// single shared multiplier are done; one angle is worked on at a time, and
// the next angle is taken only when the sequencer is back in idle.
// s_tready is high only while the sequencer is idle; a finished word waits in
// the output register, and the next angle is taken meanwhile.
// A stalled output holds the sequencer in its last step until the word leaves.
// Reset is synchronous on aresetn low and needs no clearing pass.
module knob_damping_torque_loop #(
    parameter int POLE_PAIRS = kdtl_pkg::POLE_PAIRS_DEF,
    parameter int ANGLE_BITS = kdtl_pkg::ANGLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input word
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kdtl_pkg::S_DATA_W-1:0] s_tdata,   // [11:0] angle_counts
    // result word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kdtl_pkg::M_DATA_W-1:0] m_tdata,   // [15:0] torque_cmd, [27:16] elec_angle
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdtl_pkg::APB_AW-1:0]   paddr,
    input  logic [kdtl_pkg::APB_DW-1:0]   pwdata,
    output logic [kdtl_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    kdtl_pkg::cfg_t                       cfg;
    logic                                 mode_clr;
    logic signed [kdtl_pkg::OPA_W-1:0]    op_a;
    logic signed [kdtl_pkg::OPB_W-1:0]    op_b;
    logic signed [kdtl_pkg::PROD_W-1:0]   prod;
    logic [kdtl_pkg::TORQUE_W-1:0]        torque_cmd;
    logic [kdtl_pkg::ELEC_W-1:0]          elec_angle;

    kdtl_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .mode_clr (mode_clr)
    );

    kdtl_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    kdtl_seq #(
        .POLE_PAIRS (POLE_PAIRS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .mode_clr   (mode_clr),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .angle_in   (s_tdata[kdtl_pkg::ANGLE_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .torque_cmd (torque_cmd),
        .elec_angle (elec_angle),
        .op_a       (op_a),
        .op_b       (op_b),
        .prod       (prod)
    );

    // result word packing, zero fill on top
    assign m_tdata = {4'b0, elec_angle, torque_cmd};

endmodule

[bench/knob_damping_torque_loop_test.sv]
// Self-checking bench for the knob damping torque loop: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps

module knob_damping_torque_loop_test;

    localparam int          POLE_PAIRS_TB = kdtl_pkg::POLE_PAIRS_DEF;
    localparam longint      HALF_TURN     = 2048;
    localparam longint      FULL_TURN     = 4096;
    localparam longint      SPEED_COEF    = 13107;
    localparam longint      DAMP_COEF     = 3277;
    localparam longint      SMOOTH_COEF   = 5243;
    localparam logic        MODE_NEG_FB   = 1'b0;
    localparam logic        MODE_POS_FB   = 1'b1;
    localparam logic [2:0]  REG_UNUSED    = 3'd6;
    localparam int          MAX_REPORTS   = 10;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PHASE_ITEMS   = 192;
    localparam int          NUM_PHASES    = 8;

    // Tracks the loop state and holds the words still to come out
    class torque_tracker;
        typedef struct {
            logic [kdtl_pkg::TORQUE_W-1:0] torque;
            logic [kdtl_pkg::ELEC_W-1:0]   elec;
        } torque_word_t;

        logic                        mode   = MODE_NEG_FB;
        logic [kdtl_pkg::GAIN_W-1:0] dgain  = kdtl_pkg::DGAIN_RST;
        logic [kdtl_pkg::GAIN_W-1:0] sgain  = kdtl_pkg::SGAIN_RST;
        logic [kdtl_pkg::LIM_W-1:0]  limit  = kdtl_pkg::LIM_RST;
        logic [kdtl_pkg::ELEC_W-1:0] offset = '0;

        logic [kdtl_pkg::ANGLE_W-1:0] last_angle = '0;
        longint                       fspeed     = 0;
        longint                       storque    = 0;
        bit                           primed     = 1'b0;

        torque_word_t expected_words[$];
        int           errors = 0;

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                kdtl_pkg::REG_MODE: begin
                    // any mode write restarts both filters
                    mode    = value[0];
                    primed  = 1'b0;
                    fspeed  = 0;
                    storque = 0;
                end
                kdtl_pkg::REG_DGAIN:  dgain  = value[kdtl_pkg::GAIN_W-1:0];
                kdtl_pkg::REG_SGAIN:  sgain  = value[kdtl_pkg::GAIN_W-1:0];
                kdtl_pkg::REG_LIMIT:  limit  = value[kdtl_pkg::LIM_W-1:0];
                kdtl_pkg::REG_OFFSET: offset = value[kdtl_pkg::ELEC_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_angle(logic [kdtl_pkg::ANGLE_W-1:0] angle);
            logic [kdtl_pkg::ANGLE_W-1:0] step_cnt;
            longint             spd;
            longint             gain;
            longint             raw;
            longint             lim;
            longint             coef;
            longint             cmd;
            torque_word_t       w;
            // wrapped speed, zero on the first tick after reset or mode write
            spd = 0;
            if (primed) begin
                step_cnt = angle - last_angle;
                spd = longint'(step_cnt);
                if (spd >= HALF_TURN)
                    spd -= FULL_TURN;
            end
            primed     = 1'b1;
            last_angle = angle;
            fspeed += ((spd * 256 - fspeed) * SPEED_COEF) >>> 16;
            // gain times speed, sign by mode, then clamp
            gain = longint'((mode == MODE_POS_FB) ? sgain : dgain);
            raw  = (gain * fspeed) >>> 16;
            if (mode == MODE_NEG_FB)
                raw = -raw;
            lim = longint'(limit);
            if (raw > lim)
                raw = lim;
            if (raw < -lim)
                raw = -lim;
            // output smoothing
            coef = (mode == MODE_POS_FB) ? SMOOTH_COEF : DAMP_COEF;
            storque += ((raw * 256 - storque) * coef) >>> 16;
            cmd = storque >>> 8;
            w.torque = cmd[kdtl_pkg::TORQUE_W-1:0];
            w.elec   = kdtl_pkg::ELEC_W'(angle * POLE_PAIRS_TB - offset);
            expected_words.push_back(w);
        endfunction

        function void check_word(logic [kdtl_pkg::M_DATA_W-1:0] word);
            torque_word_t w;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word %h with none expected", $realtime, word);
                return;
            end
            w = expected_words.pop_front();
            if (word[15:0] !== w.torque) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: torque_cmd expected %0d, got %0d", $realtime,
                             $signed(w.torque), $signed(word[15:0]));
            end
            if (word[27:16] !== w.elec) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: elec_angle expected %0d, got %0d", $realtime,
                             w.elec, word[27:16]);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [kdtl_pkg::S_DATA_W-1:0] s_tdata  = '0;    // [11:0] angle_counts
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [kdtl_pkg::M_DATA_W-1:0] m_tdata;          // [15:0] torque_cmd, [27:16] elec_angle
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [kdtl_pkg::APB_AW-1:0]   paddr    = '0;
    logic [kdtl_pkg::APB_DW-1:0]   pwdata   = '0;
    logic [kdtl_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    torque_tracker tracker = new;
    bit            calm          = 1'b0;
    int            stall_request = 0;

    knob_damping_torque_loop i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side: random back-pressure, or a long hold when asked
    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (stall_request != 0) begin
                hold = stall_request;
                stall_request = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_word(m_tdata);
    end

    // register write: setup cycle, then access until pready
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        tracker.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // offer one angle word, maybe after a random gap
    task automatic send_angle(input logic [kdtl_pkg::ANGLE_W-1:0] angle);
        if (!calm && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= kdtl_pkg::S_DATA_W'(angle);
        do @(posedge aclk); while (!s_tready);
        tracker.take_angle(angle);
    endtask

    // stop offering and let every expected word come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int                           ph;
        int                           i;
        int                           cur;
        int                           vel;
        int                           r;
        logic [kdtl_pkg::ANGLE_W-1:0] a;
        logic [kdtl_pkg::ANGLE_W-1:0] reset_walk [10];

        reset_walk = '{12'd100, 12'd0, 12'd2048, 12'd0, 12'd2047,
                       12'd4095, 12'd0, 12'd4095, 12'd1, 12'd3000};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: first tick, half-turn ties both ways, wrap at zero
        foreach (reset_walk[k])
            send_angle(reset_walk[k]);
        wait_drained();

        // bits above the register widths must be dropped; unused index ignored
        write_reg(REG_UNUSED,           32'hFFFF_FFFF);
        write_reg(kdtl_pkg::REG_DGAIN,  32'hFFFF_FFFF);
        write_reg(kdtl_pkg::REG_SGAIN,  32'hABCD_0000);
        write_reg(kdtl_pkg::REG_LIMIT,  32'hFFFF_FFFF);
        write_reg(kdtl_pkg::REG_OFFSET, 32'hFFFF_FFFF);
        write_reg(kdtl_pkg::REG_MODE,   32'hFFFF_FFFE);

        // full-speed sweep to push damping torque into the clamp
        a = '0;
        repeat (8) begin
            send_angle(a);
            a = a + 12'd2047;
        end
        wait_drained();

        // smooth mode at full gain, then the same mode written again
        write_reg(kdtl_pkg::REG_SGAIN, 32'h0000_FFFF);
        write_reg(kdtl_pkg::REG_MODE, {31'd0, MODE_POS_FB});
        a = '0;
        repeat (4) begin
            send_angle(a);
            a = a + 12'd2048;
        end
        wait_drained();
        write_reg(kdtl_pkg::REG_MODE, {31'd0, MODE_POS_FB});
        repeat (4) begin
            send_angle(a);
            a = a + 12'd1000;
        end

        // random phases, each with its own register settings
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            calm = (ph == 3);
            write_reg(kdtl_pkg::REG_DGAIN,
                      (ph == 0) ? 32'd65535 : (ph == 6) ? 32'd0 : $urandom);
            write_reg(kdtl_pkg::REG_SGAIN,
                      (ph == 1) ? 32'd65535 : (ph == 7) ? 32'd0 : $urandom);
            write_reg(kdtl_pkg::REG_LIMIT,
                      (ph < 2) ? 32'd32767 : (ph == 4) ? 32'd0 : $urandom);
            write_reg(kdtl_pkg::REG_OFFSET,
                      (ph == 3) ? 32'd4095 : (ph == 5) ? 32'd0 : $urandom);
            write_reg(kdtl_pkg::REG_MODE, {31'd0, ph[0] ? MODE_POS_FB : MODE_NEG_FB});

            // long receiver hold while words keep coming
            if (ph == 2)
                stall_request = 400;

            cur = $urandom_range(4095);
            vel = int'($urandom_range(64)) - 32;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // sender waits for the block to run dry once
                if (ph == 5 && i == PHASE_ITEMS / 2)
                    wait_drained();
                // mostly steady rotation, with jumps and speed changes
                r = $urandom_range(99);
                if (r < 8) begin
                    cur = $urandom_range(4095);
                end else begin
                    if (r < 18)
                        vel = $urandom_range(1) ? int'($urandom_range(64)) - 32
                                                : int'($urandom_range(4095)) - 2048;
                    cur = cur + vel + int'($urandom_range(4)) - 2;
                end
                send_angle(cur[kdtl_pkg::ANGLE_W-1:0]);
            end
        end
        calm = 1'b0;

        // drain and wrap up
        wait_drained();
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
